// File: sv/priority_counting_semaphore_macros.svh
// ----------------------------------------------------------------------------
// priority counting semaphore assertion macros
// shared property forms for the semaphore checks
// ----------------------------------------------------------------------------
`ifndef PRIORITY_COUNTING_SEMAPHORE_MACROS_SVH
`define PRIORITY_COUNTING_SEMAPHORE_MACROS_SVH

// condition holds at every edge out of reset
`define PCS_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define PCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg
// request and result types, codes and cell control structs of the semaphore
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcs_pkg;

    localparam int TASK_W    = 4;
    localparam int COUNT_W   = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [1:0] FUNC_GET      = 2'd0;
    localparam logic [1:0] FUNC_SEND     = 2'd1;
    localparam logic [1:0] FUNC_SEND_ALL = 2'd2;

    localparam logic [2:0] ST_GRANTED  = 3'd0;
    localparam logic [2:0] ST_QUEUED   = 3'd1;
    localparam logic [2:0] ST_REJECTED = 3'd2;
    localparam logic [2:0] ST_WOKEN    = 3'd3;
    localparam logic [2:0] ST_NOTHING  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TASK_ID  = 1'd1;

    typedef struct packed {
        logic [1:0]         func;
        logic [TASK_W-1:0]  task_id;
        logic [7:0]         priority_req;
        logic [7:0]         amount;
    } t_req;

    typedef struct packed {
        logic [2:0]         status;
        logic [TASK_W-1:0]  woken_task;
        logic [COUNT_W-1:0] count_after;
        logic               last;
    } t_resp;

    // wait queue cell control
    typedef struct packed {
        logic              insert;
        logic              pop;
        logic [TASK_W-1:0] new_task;
    } t_qctl;

    // wake stack cell control
    typedef struct packed {
        logic push;
        logic pop;
    } t_sctl;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RESP = 4'b0010,
        S_POP  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

endpackage

// File: sv/priority_counting_semaphore.sv
// ----------------------------------------------------------------------------
// priority_counting_semaphore
// counting semaphore with a priority sorted wait queue held in a row of cells
//
//   channel   direction  handshake               payload
//   in        request    i_in_valid / o_in_stall  t_req
//   out       result     o_out_valid / i_out_stall t_resp
//   cfg       write      i_cfg_valid / o_cfg_ready index + data
//
// get, send of zero, and sends that wake nobody: one result per request, held in
// the pending register, then moved into the output register when it is free.
// send waking n tasks: n pops of the queue head into the wake stack, then n
// results emitted from the stack top; no new request is taken until all are out.
// reset empties the queue and clears the count, no sweep.
// a stalled output holds the result; the wake stack does not pop meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "priority_counting_semaphore_macros.svh"

module priority_counting_semaphore #(
    parameter int MAX_WAITERS = 16,
    parameter int PRIO_BITS   = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  pcs_pkg::t_req                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output pcs_pkg::t_resp                o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pcs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data
);
    import pcs_pkg::*;

    localparam int UW = $clog2(MAX_WAITERS + 1);

    t_state             r_state, n_state;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [UW-1:0]      r_used, n_used;
    logic [TASK_W-1:0]  r_idle, n_idle;
    logic [UW-1:0]      r_left, n_left;
    logic [UW-1:0]      r_nwake, n_nwake;
    t_resp              r_pend, n_pend;
    logic               r_out_valid, n_out_valid;
    t_resp              r_out, n_out;

    t_qctl                qctl;
    t_sctl                sctl;
    logic [PRIO_BITS-1:0] req_prio;

    logic [TASK_W-1:0]    q_task [MAX_WAITERS];
    logic [PRIO_BITS-1:0] q_prio [MAX_WAITERS];
    logic [MAX_WAITERS-1:0] q_ins, q_match, q_occ;
    logic [TASK_W-1:0]    s_task [MAX_WAITERS];

    logic          in_acc, cfg_acc, out_free;
    logic [7:0]    used8;
    logic [UW-1:0] rel;
    logic [8:0]    sum;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign req_prio    = PRIO_BITS'(i_in_data.priority_req);

    // wait queue row, head at cell zero
    for (genvar i = 0; i < MAX_WAITERS; i++) begin : g_queue
        logic                 left_ins;
        logic [TASK_W-1:0]    left_task, right_task;
        logic [PRIO_BITS-1:0] left_prio, right_prio;

        assign q_occ[i] = (UW'(i) < r_used);

        if (i == 0) begin : g_head
            assign left_ins  = 1'b0;
            assign left_task = i_in_data.task_id;
            assign left_prio = req_prio;
        end else begin : g_mid
            assign left_ins  = q_ins[i-1];
            assign left_task = q_task[i-1];
            assign left_prio = q_prio[i-1];
        end

        if (i == MAX_WAITERS - 1) begin : g_tail
            assign right_task = q_task[i];
            assign right_prio = q_prio[i];
        end else begin : g_body
            assign right_task = q_task[i+1];
            assign right_prio = q_prio[i+1];
        end

        pcs_queue_cell #(
            .PRIO_BITS (PRIO_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (qctl),
            .i_new_prio   (req_prio),
            .i_occupied   (q_occ[i]),
            .i_left_ins   (left_ins),
            .i_left_task  (left_task),
            .i_left_prio  (left_prio),
            .i_right_task (right_task),
            .i_right_prio (right_prio),
            .o_task       (q_task[i]),
            .o_prio       (q_prio[i]),
            .o_ins        (q_ins[i]),
            .o_match      (q_match[i])
        );
    end

    // wake stack row, top at cell zero
    for (genvar j = 0; j < MAX_WAITERS; j++) begin : g_stack
        logic [TASK_W-1:0] left_task, right_task;

        if (j == 0) begin : g_top
            assign left_task = q_task[0];
        end else begin : g_mid
            assign left_task = s_task[j-1];
        end

        if (j == MAX_WAITERS - 1) begin : g_bottom
            assign right_task = s_task[j];
        end else begin : g_body
            assign right_task = s_task[j+1];
        end

        pcs_stack_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (sctl),
            .i_left_task  (left_task),
            .i_right_task (right_task),
            .o_task       (s_task[j])
        );
    end

    assign used8 = 8'(r_used);
    assign rel   = (i_in_data.amount < used8) ? UW'(i_in_data.amount) : r_used;
    assign sum   = {1'b0, r_count} + {1'b0, i_in_data.amount - 8'(rel)};

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_used      = r_used;
        n_idle      = r_idle;
        n_left      = r_left;
        n_nwake     = r_nwake;
        n_pend      = r_pend;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        qctl        = '{insert: 1'b0, pop: 1'b0, new_task: i_in_data.task_id};
        sctl        = '{push: 1'b0, pop: 1'b0};

        if (o_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (cfg_acc) begin
            priority if (i_cfg_index == CFG_INITIAL_COUNT) begin
                n_count = i_cfg_data;
                n_used  = '0;
            end else if (i_cfg_index == CFG_IDLE_TASK_ID) begin
                n_idle = i_cfg_data[TASK_W-1:0];
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_pend  = '{status: ST_NOTHING, woken_task: '0,
                                count_after: r_count, last: 1'b1};
                    n_state = S_RESP;
                    priority if (i_in_data.func == FUNC_GET) begin
                        priority if (i_in_data.task_id == r_idle || |q_match) begin
                            n_pend.status = ST_REJECTED;
                        end else if (r_count != '0) begin
                            n_count       = r_count - COUNT_W'(1);
                            n_pend.status = ST_GRANTED;
                        end else if (r_used == UW'(MAX_WAITERS)) begin
                            n_pend.status = ST_REJECTED;
                        end else begin
                            qctl.insert   = 1'b1;
                            n_used        = r_used + UW'(1);
                            n_pend.status = ST_QUEUED;
                        end
                        n_pend.count_after = n_count;
                    end else if (i_in_data.func == FUNC_SEND) begin
                        if (i_in_data.amount != '0) begin
                            n_count            = sum[8] ? 8'hff : sum[7:0];
                            n_pend.count_after = n_count;
                            if (rel != '0) begin
                                n_left  = rel;
                                n_nwake = rel;
                                n_state = S_POP;
                            end
                        end
                    end else if (i_in_data.func == FUNC_SEND_ALL) begin
                        if (r_used != '0) begin
                            n_left  = r_used;
                            n_nwake = r_used;
                            n_state = S_POP;
                        end
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_POP: begin
                qctl.pop  = 1'b1;
                sctl.push = 1'b1;
                n_used    = r_used - UW'(1);
                n_left    = r_left - UW'(1);
                if (r_left == UW'(1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out       = '{status: ST_WOKEN, woken_task: s_task[0],
                                    count_after: r_count, last: (r_nwake == UW'(1))};
                    n_out_valid = 1'b1;
                    sctl.pop    = 1'b1;
                    n_nwake     = r_nwake - UW'(1);
                    if (r_nwake == UW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_used      <= '0;
            r_idle      <= '0;
            r_left      <= '0;
            r_nwake     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_used      <= n_used;
            r_idle      <= n_idle;
            r_left      <= n_left;
            r_nwake     <= n_nwake;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `PCS_ASSERT_ALWAYS(a_used_bound, i_clk, i_rst_n, r_used <= UW'(MAX_WAITERS), "queue overfilled")
    `PCS_ASSERT_ALWAYS(a_pop_nonempty, i_clk, i_rst_n, r_state != S_POP || r_used != '0, "pop of empty queue")
    `PCS_ASSERT_ALWAYS(a_emit_pending, i_clk, i_rst_n, r_state != S_EMIT || r_nwake != '0, "emit with no woken task")
    `PCS_ASSERT_NEXT(a_get_resp, i_clk, i_rst_n, in_acc && i_in_data.func == FUNC_GET, r_state == S_RESP, "get without single result")

endmodule

// File: sv/pcs_queue_cell.sv
// ----------------------------------------------------------------------------
// pcs_queue_cell
// priority sorted wait queue entry: insert shifts to tail, pop shifts to head
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcs_queue_cell #(
    parameter int PRIO_BITS = 8
) (
    input  logic                      i_clk,
    input  pcs_pkg::t_qctl            i_ctl,
    input  logic [PRIO_BITS-1:0]      i_new_prio,
    input  logic                      i_occupied,
    input  logic                      i_left_ins,
    input  logic [pcs_pkg::TASK_W-1:0] i_left_task,
    input  logic [PRIO_BITS-1:0]      i_left_prio,
    input  logic [pcs_pkg::TASK_W-1:0] i_right_task,
    input  logic [PRIO_BITS-1:0]      i_right_prio,
    output logic [pcs_pkg::TASK_W-1:0] o_task,
    output logic [PRIO_BITS-1:0]      o_prio,
    output logic                      o_ins,
    output logic                      o_match
);
    import pcs_pkg::*;

    logic [TASK_W-1:0]    r_task, n_task;
    logic [PRIO_BITS-1:0] r_prio, n_prio;

    // empty entries count as insert points, so the flag rises once along the row
    assign o_ins   = i_occupied ? (i_new_prio < r_prio) : 1'b1;
    assign o_match = i_occupied && (r_task == i_ctl.new_task);

    always_comb begin
        n_task = r_task;
        n_prio = r_prio;
        priority if (i_ctl.pop) begin
            n_task = i_right_task;
            n_prio = i_right_prio;
        end else if (i_ctl.insert && o_ins && !i_left_ins) begin
            n_task = i_ctl.new_task;
            n_prio = i_new_prio;
        end else if (i_ctl.insert && o_ins) begin
            n_task = i_left_task;
            n_prio = i_left_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_task <= n_task;
        r_prio <= n_prio;
    end

    assign o_task = r_task;
    assign o_prio = r_prio;

endmodule

// File: sv/pcs_stack_cell.sv
// ----------------------------------------------------------------------------
// pcs_stack_cell
// one entry of the wake stack, reverses the release order of woken tasks
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcs_stack_cell (
    input  logic                       i_clk,
    input  pcs_pkg::t_sctl             i_ctl,
    input  logic [pcs_pkg::TASK_W-1:0] i_left_task,
    input  logic [pcs_pkg::TASK_W-1:0] i_right_task,
    output logic [pcs_pkg::TASK_W-1:0] o_task
);
    import pcs_pkg::*;

    logic [TASK_W-1:0] r_task, n_task;

    always_comb begin
        n_task = r_task;
        priority if (i_ctl.push) begin
            n_task = i_left_task;
        end else if (i_ctl.pop) begin
            n_task = i_right_task;
        end
    end

    always_ff @(posedge i_clk) begin
        r_task <= n_task;
    end

    assign o_task = r_task;

endmodule
